### hw/rtl/rv32x_pkg.sv
// Package for the RV32IM execute unit: request/response structs, op codes.
// No dependencies.
package rv32x_pkg;

   localparam logic [3:0] OP_LUI    = 4'd0;
   localparam logic [3:0] OP_AUIPC  = 4'd1;
   localparam logic [3:0] OP_JAL    = 4'd2;
   localparam logic [3:0] OP_JALR   = 4'd3;
   localparam logic [3:0] OP_IMM    = 4'd4;
   localparam logic [3:0] OP_REG    = 4'd5;
   localparam logic [3:0] OP_LOAD   = 4'd6;
   localparam logic [3:0] OP_STORE  = 4'd7;
   localparam logic [3:0] OP_BRANCH = 4'd8;
   localparam logic [3:0] OP_FENCE  = 4'd9;
   localparam logic [3:0] OP_HALT   = 4'd10;

   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;

   localparam logic [2:0] F3_MUL    = 3'd0;
   localparam logic [2:0] F3_MULH   = 3'd1;
   localparam logic [2:0] F3_MULHSU = 3'd2;
   localparam logic [2:0] F3_MULHU  = 3'd3;
   localparam logic [2:0] F3_DIV    = 3'd4;
   localparam logic [2:0] F3_DIVU   = 3'd5;
   localparam logic [2:0] F3_REM    = 3'd6;
   localparam logic [2:0] F3_REMU   = 3'd7;

   // number of divider cells; each retires one quotient bit
   localparam int DIV_CELLS = 32;

   typedef struct packed {
      logic [3:0]         op_class;
      logic [2:0]         funct3;
      logic [6:0]         funct7;
      logic signed [31:0] rs1_value;
      logic signed [31:0] rs2_value;
      logic signed [31:0] immediate;
      logic [31:0]        instr_pc;
      logic [4:0]         dest_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               rd_wen;
      logic [4:0]         write_index;
      logic               load_en;
      logic               store_en;
      logic [31:0]        mem_address;
      logic signed [31:0] store_data;
      logic               redirect;
      logic [31:0]        target_pc;
      logic               halt;
   } rsp_type;

   // divide state handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic [31:0] rem;
      logic [31:0] quo;    // dividend shifts out on top, quotient in at bottom
      logic [31:0] dvs;    // divisor magnitude
      logic        neg_q;
      logic        neg_r;
      logic        want_rem;
      logic        special; // div by zero or overflow, value in spec_val
      logic [31:0] spec_val;
      logic        use_div;
      logic [31:0] early;  // result when not a divide
      rsp_type     rsp;
   } cell_type;

endpackage

### hw/rtl/rv32x_cell.sv
// One divider cell: a restoring step plus a register to the next cell.
// Depends on rv32x_pkg.
module rv32x_cell (
   input  logic                clock,
   input  logic                reset,
   input  rv32x_pkg::cell_type cell_in,
   output rv32x_pkg::cell_type cell_out
);
   logic [32:0] trial;
   logic [31:0] shifted;
   rv32x_pkg::cell_type next_in;
   rv32x_pkg::cell_type data_ff;
   logic                valid_ff;

   // shift in the next dividend bit, subtract if it fits
   always_comb begin
      next_in = cell_in;
      shifted = {cell_in.rem[30:0], cell_in.quo[31]};
      trial   = {1'b0, shifted} - {1'b0, cell_in.dvs};
      if (!trial[32] && !cell_in.rem[31]) begin
         next_in.rem = trial[31:0];
         next_in.quo = {cell_in.quo[30:0], 1'b1};
      end else if (cell_in.rem[31]) begin
         // 33-bit partial remainder always exceeds divisor
         next_in.rem = shifted - cell_in.dvs;
         next_in.quo = {cell_in.quo[30:0], 1'b1};
      end else begin
         next_in.rem = shifted;
         next_in.quo = {cell_in.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= next_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end
endmodule

### hw/rtl/rv32x_front.sv
// Front stage: decode, ALU, branch, multiply, divide setup. Registered output.
// Depends on rv32x_pkg.
module rv32x_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rv32x_pkg::req_type  req_data,
   output rv32x_pkg::cell_type cell_out
);
   logic [31:0] a, b, imm, pc, opb, alu, res;
   logic        alt, lt_s, lt_u, taken;
   logic [4:0]  sh;
   rv32x_pkg::rsp_type rsp;
   logic        is_md, is_div, an, bn, sgn;
   logic [31:0] ma, mb;
   logic [65:0] prod;
   logic [32:0] ma33, mb33;
   rv32x_pkg::cell_type cell_in, cell_ff;
   logic        valid_ff;

   assign a   = req_data.rs1_value;
   assign b   = req_data.rs2_value;
   assign imm = req_data.immediate;
   assign pc  = req_data.instr_pc;

   // base ALU
   always_comb begin
      if (req_data.op_class == rv32x_pkg::OP_IMM) begin
         opb = imm;
         alt = (req_data.funct3 == 3'd5) && (req_data.funct7 == rv32x_pkg::F7_ALT);
      end else begin
         opb = b;
         alt = (req_data.funct7 == rv32x_pkg::F7_ALT);
      end
      sh   = opb[4:0];
      lt_s = $signed(a) < $signed(opb);
      lt_u = a < opb;
      case (req_data.funct3)
         3'd0:    alu = alt ? a - opb : a + opb;
         3'd1:    alu = a << sh;
         3'd2:    alu = {31'd0, lt_s};
         3'd3:    alu = {31'd0, lt_u};
         3'd4:    alu = a ^ opb;
         3'd5:    alu = alt ? 32'($signed(a) >>> sh) : a >> sh;
         3'd6:    alu = a | opb;
         default: alu = a & opb;
      endcase
   end

   // multiply (33x33 signed, one per cycle)
   always_comb begin
      ma33 = {(req_data.funct3 == rv32x_pkg::F3_MULH || req_data.funct3 ==
               rv32x_pkg::F3_MULHSU) & a[31], a};
      mb33 = {(req_data.funct3 == rv32x_pkg::F3_MULH) & b[31], b};
      prod = 66'($signed(ma33) * $signed(mb33));
   end

   // decode
   always_comb begin
      rsp    = '0;
      is_md  = (req_data.op_class == rv32x_pkg::OP_REG) &&
               (req_data.funct7 == rv32x_pkg::F7_MULDIV);
      is_div = is_md && req_data.funct3[2];
      case (req_data.funct3)
         3'd0:    taken = a == b;
         3'd1:    taken = a != b;
         3'd4:    taken = $signed(a) < $signed(b);
         3'd5:    taken = !($signed(a) < $signed(b));
         3'd6:    taken = a < b;
         3'd7:    taken = a >= b;
         default: taken = 1'b0;
      endcase
      res = 32'd0;
      case (req_data.op_class)
         rv32x_pkg::OP_LUI: begin
            res = imm; rsp.rd_wen = 1'b1;
         end
         rv32x_pkg::OP_AUIPC: begin
            res = pc + imm; rsp.rd_wen = 1'b1;
         end
         rv32x_pkg::OP_JAL: begin
            res = pc + 32'd4; rsp.rd_wen = 1'b1;
            rsp.redirect = 1'b1; rsp.target_pc = pc + imm;
         end
         rv32x_pkg::OP_JALR: begin
            res = pc + 32'd4; rsp.rd_wen = 1'b1;
            rsp.redirect = 1'b1; rsp.target_pc = (a + imm) & ~32'd1;
         end
         rv32x_pkg::OP_IMM: begin
            res = alu; rsp.rd_wen = 1'b1;
         end
         rv32x_pkg::OP_REG: begin
            rsp.rd_wen = 1'b1;
            if (is_md) begin
               res = (req_data.funct3 == rv32x_pkg::F3_MUL) ? prod[31:0] : prod[63:32];
            end else begin
               res = alu;
            end
         end
         rv32x_pkg::OP_LOAD: begin
            rsp.mem_address = a + imm; rsp.load_en = 1'b1; rsp.rd_wen = 1'b1;
         end
         rv32x_pkg::OP_STORE: begin
            rsp.mem_address = a + imm; rsp.store_data = b; rsp.store_en = 1'b1;
         end
         rv32x_pkg::OP_BRANCH: begin
            rsp.redirect  = taken;
            rsp.target_pc = taken ? pc + imm : 32'd0;
         end
         rv32x_pkg::OP_HALT: rsp.halt = 1'b1;
         default: ;
      endcase
      rsp.write_index = rsp.rd_wen ? req_data.dest_index : 5'd0;
   end

   // divider setup
   always_comb begin
      sgn = !req_data.funct3[0];
      an  = sgn & a[31];
      bn  = sgn & b[31];
      ma  = an ? 32'(-a) : a;
      mb  = bn ? 32'(-b) : b;
      cell_in          = '0;
      cell_in.valid    = start;
      cell_in.quo      = ma;
      cell_in.dvs      = mb;
      cell_in.neg_q    = an ^ bn;
      cell_in.neg_r    = an;
      cell_in.want_rem = req_data.funct3[1];
      cell_in.use_div  = is_div;
      cell_in.early    = res;
      cell_in.rsp      = rsp;
      if (b == 32'd0) begin
         cell_in.special  = 1'b1;
         cell_in.spec_val = req_data.funct3[1] ? a : 32'hFFFF_FFFF;
      end else if (sgn && a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
         cell_in.special  = 1'b1;
         cell_in.spec_val = req_data.funct3[1] ? 32'd0 : a;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
   end

   always_comb begin
      cell_out       = cell_ff;
      cell_out.valid = valid_ff;
   end
endmodule

### hw/rtl/rv32im_execute_unit_top.sv
// RV32IM execute unit, fully pipelined: front stage then 32 divider cells.
// Every request passes the front register and all cell registers, so results stay in order;
// throughput is one request per cycle, busy is always low.
// Depth is set by the chain of 32 one-bit restoring divide cells.
// Synchronous active-high reset clears all valid bits; no results follow it.
// Depends on rv32x_pkg, rv32x_front, rv32x_cell.
module rv32im_execute_unit_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rv32x_pkg::req_type req_data,
   output logic               rsp_strobe,
   output rv32x_pkg::rsp_type rsp_data
);
   rv32x_pkg::cell_type chain [rv32x_pkg::DIV_CELLS+1];
   rv32x_pkg::cell_type last;
   logic [31:0] q, r, v;

   assign busy = 1'b0;

   rv32x_front u_front (
      .clock(clock), .reset(reset), .start(start & ~busy),
      .req_data(req_data), .cell_out(chain[0])
   );

   for (genvar i = 0; i < rv32x_pkg::DIV_CELLS; i++) begin : g_cell
      rv32x_cell u_cell (
         .clock(clock), .reset(reset), .cell_in(chain[i]), .cell_out(chain[i+1])
      );
   end

   // final sign fix and result select
   always_comb begin
      last = chain[rv32x_pkg::DIV_CELLS];
      q    = last.neg_q ? 32'(-last.quo) : last.quo;
      r    = last.neg_r ? 32'(-last.rem) : last.rem;
      if (!last.use_div)     v = last.early;
      else if (last.special) v = last.spec_val;
      else                   v = last.want_rem ? r : q;
      rsp_data              = last.rsp;
      rsp_data.result_value = v;
      rsp_strobe            = last.valid;
   end

   // a response strobes only where a request was started one pipeline depth earlier
   property p_latency;
      @(posedge clock) disable iff (reset)
         rsp_strobe |-> $past(start, rv32x_pkg::DIV_CELLS + 1);
   endproperty
   assert property (p_latency) else $error("response without request");

   property p_wi;
      @(posedge clock) disable iff (reset)
         rsp_strobe && !rsp_data.rd_wen |-> rsp_data.write_index == 5'd0;
   endproperty
   assert property (p_wi) else $error("write index without write");

   property p_mem;
      @(posedge clock) disable iff (reset)
         rsp_strobe |-> !(rsp_data.load_en && rsp_data.store_en);
   endproperty
   assert property (p_mem) else $error("load and store together");
endmodule

### sim/rv32im_execute_checker.sv
`timescale 1ns / 1ps
// Checker for the RV32IM execute unit: watches request and response channels,
// predicts each response and compares it field by field. Depends on rv32x_pkg.
module rv32im_execute_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  rv32x_pkg::req_type req_data,
   input  logic               rsp_strobe,
   input  rv32x_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending_count
);
   rv32x_pkg::rsp_type expected_rsps[$];

   function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   // base integer ALU: add/sub, shifts, compares, logic
   function automatic logic [31:0] int_alu(logic [31:0] a, logic [31:0] b,
                                           logic [2:0] f3, logic alt);
      case (f3)
         3'd0: return alt ? a - b : a + b;
         3'd1: return a << b[4:0];
         3'd2: return {31'b0, signed_less(a, b)};
         3'd3: return {31'b0, a < b};
         3'd4: return a ^ b;
         3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
         3'd6: return a | b;
         default: return a & b;
      endcase
   endfunction

   // multiply/divide group, with divide-by-zero and overflow results
   function automatic logic [31:0] mul_div(logic [31:0] a, logic [31:0] b,
                                           logic [2:0] f3);
      logic signed [63:0] sa, sb;
      logic [63:0] p;
      sa = $signed(a);
      sb = $signed(b);
      case (f3)
         rv32x_pkg::F3_MUL:    return a * b;
         rv32x_pkg::F3_MULH:   begin p = sa * sb; return p[63:32]; end
         rv32x_pkg::F3_MULHSU: begin p = sa * $signed({32'b0, b}); return p[63:32]; end
         rv32x_pkg::F3_MULHU:  begin p = {32'b0, a} * {32'b0, b}; return p[63:32]; end
         rv32x_pkg::F3_DIV: begin
            if (b == 32'd0) return 32'hFFFF_FFFF;
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
            return 32'(sa / sb);
         end
         rv32x_pkg::F3_DIVU: return (b == 32'd0) ? 32'hFFFF_FFFF : a / b;
         rv32x_pkg::F3_REM: begin
            if (b == 32'd0) return a;
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
            return 32'(sa % sb);
         end
         default: return (b == 32'd0) ? a : a % b;
      endcase
   endfunction

   function automatic rv32x_pkg::rsp_type execute(rv32x_pkg::req_type r);
      rv32x_pkg::rsp_type o;
      logic [31:0] a, b, imm, pc;
      logic taken;
      o = '0;
      a = r.rs1_value;
      b = r.rs2_value;
      imm = r.immediate;
      pc = r.instr_pc;
      taken = 1'b0;
      case (r.op_class)
         rv32x_pkg::OP_LUI:   begin o.result_value = imm; o.rd_wen = 1'b1; end
         rv32x_pkg::OP_AUIPC: begin o.result_value = pc + imm; o.rd_wen = 1'b1; end
         rv32x_pkg::OP_JAL: begin
            o.result_value = pc + 32'd4; o.rd_wen = 1'b1;
            o.redirect = 1'b1; o.target_pc = pc + imm;
         end
         rv32x_pkg::OP_JALR: begin
            o.result_value = pc + 32'd4; o.rd_wen = 1'b1;
            o.redirect = 1'b1; o.target_pc = (a + imm) & ~32'd1;
         end
         rv32x_pkg::OP_IMM: begin
            // only SRAI looks at funct7
            o.result_value = int_alu(a, imm, r.funct3,
                                     r.funct3 == 3'd5 && r.funct7 == rv32x_pkg::F7_ALT);
            o.rd_wen = 1'b1;
         end
         rv32x_pkg::OP_REG: begin
            o.result_value = (r.funct7 == rv32x_pkg::F7_MULDIV) ? mul_div(a, b, r.funct3)
                           : int_alu(a, b, r.funct3, r.funct7 == rv32x_pkg::F7_ALT);
            o.rd_wen = 1'b1;
         end
         rv32x_pkg::OP_LOAD: begin
            o.mem_address = a + imm; o.load_en = 1'b1; o.rd_wen = 1'b1;
         end
         rv32x_pkg::OP_STORE: begin
            o.mem_address = a + imm; o.store_data = b; o.store_en = 1'b1;
         end
         rv32x_pkg::OP_BRANCH: begin
            case (r.funct3)
               3'd0: taken = a == b;
               3'd1: taken = a != b;
               3'd4: taken = signed_less(a, b);
               3'd5: taken = !signed_less(a, b);
               3'd6: taken = a < b;
               3'd7: taken = a >= b;
               default: taken = 1'b0;
            endcase
            if (taken) begin
               o.redirect = 1'b1; o.target_pc = pc + imm;
            end
         end
         rv32x_pkg::OP_HALT: o.halt = 1'b1;
         default: ;
      endcase
      if (o.rd_wen) o.write_index = r.dest_index;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_rsps.size();

   // predict on accepted request, compare on response strobe
   always @(posedge clock) begin
      rv32x_pkg::rsp_type want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with no request outstanding", 32'd1, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.result_value !== want.result_value)
                  report_mismatch("result_value", rsp_data.result_value, want.result_value);
               if (rsp_data.rd_wen !== want.rd_wen)
                  report_mismatch("rd_wen", 32'(rsp_data.rd_wen), 32'(want.rd_wen));
               if (rsp_data.write_index !== want.write_index)
                  report_mismatch("write_index", 32'(rsp_data.write_index),
                                  32'(want.write_index));
               if (rsp_data.load_en !== want.load_en)
                  report_mismatch("load_en", 32'(rsp_data.load_en), 32'(want.load_en));
               if (rsp_data.store_en !== want.store_en)
                  report_mismatch("store_en", 32'(rsp_data.store_en), 32'(want.store_en));
               if (rsp_data.mem_address !== want.mem_address)
                  report_mismatch("mem_address", rsp_data.mem_address, want.mem_address);
               if (rsp_data.store_data !== want.store_data)
                  report_mismatch("store_data", rsp_data.store_data, want.store_data);
               if (rsp_data.redirect !== want.redirect)
                  report_mismatch("redirect", 32'(rsp_data.redirect), 32'(want.redirect));
               if (rsp_data.target_pc !== want.target_pc)
                  report_mismatch("target_pc", rsp_data.target_pc, want.target_pc);
               if (rsp_data.halt !== want.halt)
                  report_mismatch("halt", 32'(rsp_data.halt), 32'(want.halt));
            end
         end
         if (start && !busy)
            expected_rsps.insert(expected_rsps.size(), execute(req_data));
      end
   end
endmodule

### sim/rv32im_execute_unit_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the RV32IM execute unit: drives directed and random
// requests and gives the verdict. Depends on rv32x_pkg and the checker.
module rv32im_execute_unit_top_tb;
   localparam int LATENCY = 33;
   localparam int WATCHDOG_LIMIT = 400;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   rv32x_pkg::req_type req_data = '0;
   logic    rsp_strobe;
   rv32x_pkg::rsp_type rsp_data;
   int      fail_count, pending_count;
   int      idle_cycles = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   rv32im_execute_unit_top dut (.*);

   rv32im_execute_checker checker_inst (.*);

   // watchdog: cycles with nothing accepted on either channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("rv32im_execute_unit_top regression: fail");
         $finish;
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 40);
         5: return -$urandom_range(1, 40);
         default: return $urandom;
      endcase
   endfunction

   // one request: hold start until accepted, then optionally gap
   task automatic send(rv32x_pkg::req_type r, int gap);
      start <= 1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_op(logic [3:0] cls, logic [2:0] f3, logic [6:0] f7,
                          logic [31:0] a, logic [31:0] b, logic [31:0] imm);
      rv32x_pkg::req_type r;
      r.op_class = cls;
      r.funct3 = f3;
      r.funct7 = f7;
      r.rs1_value = a;
      r.rs2_value = b;
      r.immediate = imm;
      r.instr_pc = $urandom;
      r.dest_index = 5'($urandom);
      send(r, 0);
   endtask

   initial begin
      rv32x_pkg::req_type r;
      int gap;
      logic burst;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: classes, M-extension corner cases, branches, extremes
      send_op(rv32x_pkg::OP_LUI, 3'd0, 7'd0, 0, 0, 32'hFFFF_F000);
      send_op(rv32x_pkg::OP_AUIPC, 3'd0, 7'd0, 0, 0, 32'h8000_0000);
      send_op(rv32x_pkg::OP_JAL, 3'd0, 7'd0, 0, 0, -4);
      send_op(rv32x_pkg::OP_JALR, 3'd0, 7'd0, 32'h1235, 0, 32'hFFFF_FFFF);
      send_op(rv32x_pkg::OP_IMM, 3'd5, rv32x_pkg::F7_ALT, 32'h8000_0000, 0, 31);
      send_op(rv32x_pkg::OP_IMM, 3'd5, 7'h7F, 32'h8000_0000, 0, 32'h3F);
      send_op(rv32x_pkg::OP_REG, 3'd0, rv32x_pkg::F7_ALT, 0, 32'h8000_0000, 0);
      send_op(rv32x_pkg::OP_REG, 3'd5, 7'h55, 32'hFFFF_FFFF, 4, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_DIV, rv32x_pkg::F7_MULDIV,
              32'h8000_0000, 32'hFFFF_FFFF, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_REM, rv32x_pkg::F7_MULDIV,
              32'h8000_0000, 32'hFFFF_FFFF, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_DIV, rv32x_pkg::F7_MULDIV,
              32'h7FFF_FFFF, 0, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_DIVU, rv32x_pkg::F7_MULDIV, 5, 0, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_REM, rv32x_pkg::F7_MULDIV,
              32'hFFFF_FFF9, 0, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_REMU, rv32x_pkg::F7_MULDIV,
              32'hFFFF_FFFF, 0, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_MULH, rv32x_pkg::F7_MULDIV,
              32'h8000_0000, 32'h8000_0000, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_MULHSU, rv32x_pkg::F7_MULDIV,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_op(rv32x_pkg::OP_REG, rv32x_pkg::F3_MULHU, rv32x_pkg::F7_MULDIV,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_op(rv32x_pkg::OP_LOAD, 3'd0, 7'd0, 32'hFFFF_FFFF, 0, 1);
      send_op(rv32x_pkg::OP_STORE, 3'd0, 7'd0, 32'h10, 32'h8000_0000, -16);
      for (int f = 0; f < 8; f++)
         send_op(rv32x_pkg::OP_BRANCH, 3'(f), 7'd0, 32'h8000_0000, 1, 8);
      send_op(rv32x_pkg::OP_FENCE, 3'd0, 7'd0, 1, 2, 3);
      send_op(rv32x_pkg::OP_HALT, 3'd0, 7'd0, 0, 0, 0);
      send_op(4'd15, 3'd7, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // random: each run of 100 requests is at random a burst without gaps or a gappy stretch
      burst = 0;
      for (int i = 0; i < 1950; i++) begin
         if (i % 100 == 0) burst = 1'($urandom_range(0, 1));
         r.op_class = ($urandom_range(0, 9) < 4) ? rv32x_pkg::OP_REG : 4'($urandom);
         r.funct3 = 3'($urandom);
         case ($urandom_range(0, 3))
            0: r.funct7 = rv32x_pkg::F7_MULDIV;
            1: r.funct7 = rv32x_pkg::F7_ALT;
            2: r.funct7 = 7'd0;
            default: r.funct7 = 7'($urandom);
         endcase
         r.rs1_value = pick_operand();
         r.rs2_value = ($urandom_range(0, 7) == 0) ? r.rs1_value : pick_operand();
         r.immediate = pick_operand();
         r.instr_pc = $urandom;
         r.dest_index = 5'($urandom);
         gap = burst ? 0 : $urandom_range(0, 7);
         send(r, gap);
         // drain the pipe once midway
         if (i == 900) begin
            start <= 0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
      end
      start <= 0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("rv32im_execute_unit_top regression: pass");
      else
         $display("rv32im_execute_unit_top regression: fail");
      $finish;
   end
endmodule
